@@ hdl/olst_pkg.sv @@
// ----------------------------------------------------------------------------
// olst_pkg: shared definitions for the ordered list store
// Sizes, operation and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package olst_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_REMOVE     = 2'd2,
    OP_DUMP       = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } st_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted word
    logic push;         // link a new entry at the front or back
    logic walk_first;   // read the head entry, clear the walk index
    logic walk_step;    // read the entry after the current one
    logic unlink;       // remove the current entry from the list
    logic set_status;   // record the status of a single result
    st_e  status;
    logic emit_entry;   // load the output register with the current entry
    logic emit_result;  // load the output register with the recorded status
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic match;
    logic at_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/olst_in_if.sv @@
// ----------------------------------------------------------------------------
// olst_in_if: request channel of the ordered list store
// Carries one operation and its value under a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface olst_in_if;

  logic                                   valid;
  logic                                   ready;
  logic [olst_pkg::OP_W-1:0]              operation;
  logic signed [olst_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);

endinterface

`default_nettype wire

@@ hdl/olst_out_if.sv @@
// ----------------------------------------------------------------------------
// olst_out_if: response channel of the ordered list store
// Carries one result word under a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface olst_out_if;

  logic                                   valid;
  logic                                   ready;
  logic signed [olst_pkg::VALUE_WIDTH-1:0] value_res;
  logic [olst_pkg::ST_W-1:0]              status;
  logic                                   last;
  logic [olst_pkg::CNT_W-1:0]             count;

  modport source (output valid, output value_res, output status, output last,
                  output count, input ready);
  modport sink   (input valid, input value_res, input status, input last,
                  input count, output ready);

endinterface

`default_nettype wire

@@ hdl/olst_ctrl.sv @@
// ----------------------------------------------------------------------------
// olst_ctrl: controller of the ordered list store
// Sequences the datapath through push, list walks and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire olst_pkg::sts_t sts_i,
  output olst_pkg::cmd_t      cmd_o
);
  import olst_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_START  = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        case (sts_i.op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            cmd_o.set_status = 1'b1;
            if (sts_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.push   = 1'b1;
              cmd_o.status = ST_OK;
            end
            state_d = S_RESULT;
          end
          OP_REMOVE: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOT_FOUND;
              state_d          = S_RESULT;
            end else begin
              cmd_o.walk_first = 1'b1;
              state_d          = S_WALK;
            end
          end
          default: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
              state_d          = S_RESULT;
            end else begin
              cmd_o.walk_first = 1'b1;
              state_d          = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        if (sts_i.op == OP_REMOVE) begin
          if (sts_i.match) begin
            cmd_o.unlink     = 1'b1;
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_OK;
            state_d          = S_RESULT;
          end else if (sts_i.at_last) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_NOT_FOUND;
            state_d          = S_RESULT;
          end else begin
            cmd_o.walk_step = 1'b1;
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit_entry = 1'b1;
          if (sts_i.at_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.walk_step = 1'b1;
          end
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/olst_dpath.sv @@
// ----------------------------------------------------------------------------
// olst_dpath: datapath of the ordered list store
// Slot memories with links, head/tail/count/free map, walk cursor and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_dpath (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire olst_pkg::cmd_t                          cmd_i,
  output olst_pkg::sts_t                               sts_o,
  input  wire logic [olst_pkg::OP_W-1:0]               req_operation_i,
  input  wire logic signed [olst_pkg::VALUE_WIDTH-1:0] req_value_i,
  input  wire logic                                    rsp_ready_i,
  output logic                                         rsp_valid_o,
  output logic signed [olst_pkg::VALUE_WIDTH-1:0]      rsp_value_res_o,
  output logic [olst_pkg::ST_W-1:0]                    rsp_status_o,
  output logic                                         rsp_last_o,
  output logic [olst_pkg::CNT_W-1:0]                   rsp_count_o
);
  import olst_pkg::*;

  // Slot memories, undefined until written.
  logic [VALUE_WIDTH-1:0] mem_val  [CAPACITY];
  logic [SLOT_W-1:0]      mem_next [CAPACITY];
  logic [SLOT_W-1:0]      mem_prev [CAPACITY];

  // List bookkeeping.
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [SLOT_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAPACITY-1:0] free_q, free_d;

  // Captured word and result status.
  op_e                    op_q;
  logic [VALUE_WIDTH-1:0] value_q;
  st_e                    res_st_q;

  // Walk cursor: slot read last, its registered contents, and its position.
  logic [SLOT_W-1:0]      cur_q;
  logic [VALUE_WIDTH-1:0] rd_val_q;
  logic [SLOT_W-1:0]      rd_next_q;
  logic [SLOT_W-1:0]      rd_prev_q;
  logic [CNT_W-1:0]       idx_q;

  // Output register.
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  st_e                    out_status_q;
  logic                   out_last_q;
  logic [CNT_W-1:0]       out_count_q;

  logic                   rd_en;
  logic [SLOT_W-1:0]      rd_addr;
  logic [SLOT_W-1:0]      new_slot;
  logic                   at_first;
  logic                   at_last;
  logic                   out_free;

  logic                   val_we;
  logic                   next_we;
  logic [SLOT_W-1:0]      next_waddr;
  logic [SLOT_W-1:0]      next_wdata;
  logic                   prev_we;
  logic [SLOT_W-1:0]      prev_waddr;
  logic [SLOT_W-1:0]      prev_wdata;

  // Lowest free slot.
  always_comb begin
    new_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        new_slot = SLOT_W'(i);
      end
    end
  end

  assign rd_en    = cmd_i.walk_first | cmd_i.walk_step;
  assign rd_addr  = cmd_i.walk_first ? head_q : rd_next_q;
  assign at_first = (idx_q == '0);
  assign at_last  = (CNT_W'(idx_q + CNT_W'(1)) == count_q);
  assign out_free = !out_valid_q || rsp_ready_i;

  assign sts_o.op       = op_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CNT_W'(CAPACITY));
  assign sts_o.match    = (rd_val_q == value_q);
  assign sts_o.at_last  = at_last;
  assign sts_o.out_free = out_free;

  // Link updates for push and unlink.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    free_d     = free_q;
    val_we     = 1'b0;
    next_we    = 1'b0;
    next_waddr = new_slot;
    next_wdata = head_q;
    prev_we    = 1'b0;
    prev_waddr = head_q;
    prev_wdata = new_slot;
    if (cmd_i.push) begin
      val_we           = 1'b1;
      free_d[new_slot] = 1'b0;
      count_d          = CNT_W'(count_q + CNT_W'(1));
      if (count_q == '0) begin
        head_d = new_slot;
        tail_d = new_slot;
      end else if (op_q == OP_PUSH_FRONT) begin
        next_we    = 1'b1;
        next_waddr = new_slot;
        next_wdata = head_q;
        prev_we    = 1'b1;
        prev_waddr = head_q;
        prev_wdata = new_slot;
        head_d     = new_slot;
      end else begin
        prev_we    = 1'b1;
        prev_waddr = new_slot;
        prev_wdata = tail_q;
        next_we    = 1'b1;
        next_waddr = tail_q;
        next_wdata = new_slot;
        tail_d     = new_slot;
      end
    end else if (cmd_i.unlink) begin
      if (at_first) begin
        head_d = rd_next_q;
      end else begin
        next_we    = 1'b1;
        next_waddr = rd_prev_q;
        next_wdata = rd_next_q;
      end
      if (at_last) begin
        tail_d = rd_prev_q;
      end else begin
        prev_we    = 1'b1;
        prev_waddr = rd_next_q;
        prev_wdata = rd_prev_q;
      end
      free_d[cur_q] = 1'b1;
      count_d       = CNT_W'(count_q - CNT_W'(1));
      if (count_q == CNT_W'(1)) begin
        head_d = '0;
        tail_d = '0;
      end
    end
  end

  // Memories with registered read.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      mem_val[new_slot] <= value_q;
    end
    if (rd_en) begin
      rd_val_q <= mem_val[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      mem_next[next_waddr] <= next_wdata;
    end
    if (rd_en) begin
      rd_next_q <= mem_next[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      mem_prev[prev_waddr] <= prev_wdata;
    end
    if (rd_en) begin
      rd_prev_q <= mem_prev[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      free_q  <= '1;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      free_q  <= free_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(req_operation_i);
      value_q <= req_value_i;
    end
    if (cmd_i.set_status) begin
      res_st_q <= cmd_i.status;
    end
    if (rd_en) begin
      cur_q <= rd_addr;
      idx_q <= cmd_i.walk_first ? '0 : CNT_W'(idx_q + CNT_W'(1));
    end
    if (cmd_i.emit_entry) begin
      out_value_q  <= rd_val_q;
      out_status_q <= ST_OK;
      out_last_q   <= at_last;
      out_count_q  <= count_q;
    end else if (cmd_i.emit_result) begin
      out_value_q  <= (res_st_q == ST_EMPTY) ? '0 : value_q;
      out_status_q <= res_st_q;
      out_last_q   <= 1'b1;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_entry || cmd_i.emit_result) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o     = out_valid_q;
  assign rsp_value_res_o = out_value_q;
  assign rsp_status_o    = out_status_q;
  assign rsp_last_o      = out_last_q;
  assign rsp_count_o     = out_count_q;

endmodule

`default_nettype wire

@@ hdl/ordered_list_store.sv @@
// ----------------------------------------------------------------------------
// ordered_list_store: bounded doubly linked list of signed values
// Push at either end, remove the first matching entry, or dump the whole
// list from front to back, one operation per request word.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Words per item    Payload
//  req_i    in   1                 operation[1:0], value[31:0] signed
//  rsp_o    out  1 .. CAPACITY     value_res[31:0] signed, status[1:0],
//                                  last, count[5:0]
//
// One request is in work at a time; req_i.ready is high only while idle.
// Push: the links are updated in the start state, then the result is loaded
// into the output register once it is free. Remove: entries are compared
// one per cycle through the slot memories' read port until a match or the
// end of the list. Dump: one entry per cycle without back-pressure; an empty
// list gives one word. A stalled rsp_o holds the walk in place.
// Reset clears head, tail, count and the free map at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  olst_in_if.sink   req_i,
  olst_out_if.source rsp_o
);
  import olst_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller owns the request handshake and steps the datapath through
  // a push, a list walk for remove or dump, and the delivery of a result.
  olst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the slot memories and links, and the output register
  // that decouples the response channel from the walk.
  olst_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_operation_i (req_i.operation),
    .req_value_i     (req_i.value),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_value_res_o (rsp_o.value_res),
    .rsp_status_o    (rsp_o.status),
    .rsp_last_o      (rsp_o.last),
    .rsp_count_o     (rsp_o.count)
  );

endmodule

`default_nettype wire

@@ hdl/olst_checker.sv @@
// ----------------------------------------------------------------------------
// olst_checker: port-level checks for the ordered list store
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_checker (
  input wire logic                                    clk_i,
  input wire logic                                    rst_ni,
  input wire logic                                    req_valid_i,
  input wire logic                                    req_ready_i,
  input wire logic                                    rsp_valid_i,
  input wire logic                                    rsp_ready_i,
  input wire logic signed [olst_pkg::VALUE_WIDTH-1:0] rsp_value_res_i,
  input wire logic [olst_pkg::ST_W-1:0]               rsp_status_i,
  input wire logic                                    rsp_last_i,
  input wire logic [olst_pkg::CNT_W-1:0]              rsp_count_i
);
  import olst_pkg::*;

  // A stalled response word holds still.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_res_i)
      && $stable(rsp_status_i) && $stable(rsp_last_i) && $stable(rsp_count_i))
    else $error("response word changed while stalled");

  // Only one request is in work: the store goes busy right after acceptance.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in work");

  // A dropped push is reported only when the store is full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FULL) |->
      (rsp_count_i == CNT_W'(CAPACITY)) && rsp_last_i)
    else $error("full status with count below capacity");

  // An empty dump is a single word with zero value and zero count.
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_EMPTY) |->
      (rsp_count_i == '0) && (rsp_value_res_i == '0) && rsp_last_i)
    else $error("malformed empty-list word");

endmodule

bind ordered_list_store olst_checker u_olst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_value_res_i (rsp_o.value_res),
  .rsp_status_i    (rsp_o.status),
  .rsp_last_i      (rsp_o.last),
  .rsp_count_i     (rsp_o.count)
);

`default_nettype wire

@@ verif/olst_list_checker.sv @@
// ----------------------------------------------------------------------------
// olst_list_checker: scoreboard for the ordered list store
// Watches the request and response channels. It keeps its own copy of the
// linked list, works out the response words for every accepted request and
// compares each accepted response word against the oldest one expected.
// ----------------------------------------------------------------------------
`default_nettype none

module olst_list_checker
  import olst_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  olst_in_if        req_i,
  olst_out_if       rsp_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    st_e                    status;
    logic                   last;
    logic [CNT_W-1:0]       count;
  } list_word_t;

  // Shadow copy of the slot store and its links.
  logic [VALUE_WIDTH-1:0] slot_value [CAPACITY];
  logic [SLOT_W-1:0]      fwd_link   [CAPACITY];
  logic [SLOT_W-1:0]      back_link  [CAPACITY];
  logic [SLOT_W-1:0]      front_slot;
  logic [SLOT_W-1:0]      back_slot;
  logic [CAPACITY-1:0]    vacant;
  int                     held;

  list_word_t expected_words [$];
  int         mismatches = 0;
  int         pending_words = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_words;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_word(input logic [VALUE_WIDTH-1:0] v, input st_e st,
                            input logic lst);
    list_word_t w;
    w.value  = v;
    w.status = st;
    w.last   = lst;
    w.count  = CNT_W'(held);
    expected_words.push_back(w);
  endtask

  task automatic apply_list_op(input op_e op, input logic [VALUE_WIDTH-1:0] v);
    int                idx;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] n;
    bit                found;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held >= CAPACITY) begin
          queue_word(v, ST_FULL, 1'b1);
        end else begin
          // The new entry takes the lowest free slot.
          s = '0;
          for (idx = CAPACITY - 1; idx >= 0; idx--) begin
            if (vacant[idx]) s = SLOT_W'(idx);
          end
          vacant[s] = 1'b0;
          slot_value[s] = v;
          if (held == 0) begin
            front_slot = s;
            back_slot  = s;
          end else if (op == OP_PUSH_FRONT) begin
            fwd_link[s] = front_slot;
            back_link[front_slot] = s;
            front_slot = s;
          end else begin
            back_link[s] = back_slot;
            fwd_link[back_slot] = s;
            back_slot = s;
          end
          held++;
          queue_word(v, ST_OK, 1'b1);
        end
      end
      OP_REMOVE: begin
        cur = front_slot;
        found = 1'b0;
        for (idx = 0; idx < held && !found; idx++) begin
          if (slot_value[cur] == v) begin
            p = back_link[cur];
            n = fwd_link[cur];
            if (idx == 0) front_slot = n;
            else fwd_link[p] = n;
            if (idx + 1 == held) back_slot = p;
            else back_link[n] = p;
            vacant[cur] = 1'b1;
            held--;
            if (held == 0) begin
              front_slot = '0;
              back_slot  = '0;
            end
            queue_word(v, ST_OK, 1'b1);
            found = 1'b1;
          end else begin
            cur = fwd_link[cur];
          end
        end
        if (!found) queue_word(v, ST_NOT_FOUND, 1'b1);
      end
      default: begin
        if (held == 0) begin
          queue_word('0, ST_EMPTY, 1'b1);
        end else begin
          cur = front_slot;
          for (idx = 0; idx < held; idx++) begin
            queue_word(slot_value[cur], ST_OK, idx + 1 == held);
            cur = fwd_link[cur];
          end
        end
      end
    endcase
  endtask

  task automatic check_word();
    list_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("response word with none expected", rsp_i.value_res, '0);
    end else begin
      want = expected_words.pop_front();
      if (rsp_i.value_res !== want.value)
        report_mismatch("value_res", rsp_i.value_res, want.value);
      if (rsp_i.status !== want.status)
        report_mismatch("status", 32'(rsp_i.status), 32'(want.status));
      if (rsp_i.last !== want.last)
        report_mismatch("last", 32'(rsp_i.last), 32'(want.last));
      if (rsp_i.count !== want.count)
        report_mismatch("count", 32'(rsp_i.count), 32'(want.count));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_slot = '0;
      back_slot  = '0;
      held       = 0;
      vacant     = '1;
      expected_words.delete();
      pending_words <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) check_word();
      if (req_i.valid && req_i.ready) apply_list_op(op_e'(req_i.operation), req_i.value);
      pending_words <= expected_words.size();
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_ordered_list_store.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_list_store: testbench for the ordered list store
// Drives request words with random gaps, stalls the response channel at
// random and once for a long stretch, and leaves prediction and checking to
// the list checker. Covers pushes at both ends, removal at the head, middle
// and tail, removal with no match, full and empty lists, and full dumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ordered_list_store;
  import olst_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 40;    // longer than a full dump of the list
  localparam int HOLD_CYCLES  = 300;   // long response stall
  localparam int IDLE_PCT     = 28;
  localparam int RANDOM_ITEMS = 130;
  localparam int POOL_SIZE    = 6;

  logic clk_i = 1'b0;
  logic rst_ni;

  // Clock with a period of ten time units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  olst_in_if  req_if ();
  olst_out_if rsp_if ();

  ordered_list_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  int fail_count;
  int pending;

  olst_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Both of these are written with nonblocking assignments by the stimulus
  // process, so the response process always sees the value from the
  // previous clock edge.
  bit quiet      = 1'b0;  // no idling on either side while set
  int hold_token = 0;     // bumped once to request the long stall

  int        items_sent = 0;
  logic [31:0] value_pool [POOL_SIZE];

  // --------------------------------------------------------------------------
  // Response side. Ready drops at random, except during the quiet stretch.
  // A change of hold_token starts the long stall, counted here.
  // --------------------------------------------------------------------------
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. A hung handshake ends the run here.
  // --------------------------------------------------------------------------
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one request word and returns at the edge where it is taken.
  // Valid is only lowered for an idle gap, never between back-to-back
  // words, so it never sees two assignments in one time step.
  task automatic send_word(input op_e op, input logic [31:0] v);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= v;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // Stops offering words until every expected response word has arrived.
  task automatic pause_for_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Full-range value, with the extremes and zero turning up often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A small pool of values keeps removals likely to hit stored entries.
  task automatic refresh_pool();
    int k;
    for (k = 0; k < POOL_SIZE; k++) value_pool[k] = pick_value();
  endtask

  function automatic logic [31:0] pool_value();
    if ($urandom_range(99) < 15) return $urandom;
    return value_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic op_e pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 25) return OP_PUSH_FRONT;
    if (r < 50) return OP_PUSH_BACK;
    if (r < 85) return OP_REMOVE;
    return OP_DUMP;
  endfunction

  // Random mix of all four operations on a fresh value pool.
  task automatic mixed_episode(input int n_words, input bit no_idle);
    int k;
    refresh_pool();
    if (no_idle) quiet <= 1'b1;
    for (k = 0; k < n_words; k++) send_word(pick_op(), pool_value());
    if (no_idle) quiet <= 1'b0;
    if ($urandom_range(1) == 1) pause_for_drain();
  endtask

  // Fills the list past capacity, dumps it under a long response stall,
  // then sends removals of pool values to take entries out again.
  task automatic fill_episode();
    int k;
    refresh_pool();
    // More pushes than the store holds, so the last ones are dropped
    // whatever the list held before.
    for (k = 0; k < CAPACITY + 4; k++)
      send_word(op_e'($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT), pool_value());
    // The stall begins while the dump of the full list is on its way; the
    // words after it pile up at the request side.
    hold_token <= hold_token + 1;
    send_word(OP_DUMP, $urandom);
    send_word(OP_PUSH_FRONT, pool_value());
    send_word(OP_PUSH_BACK, pool_value());
    send_word(OP_DUMP, $urandom);
    pause_for_drain();
    for (k = 0; k < CAPACITY + 2; k++) send_word(OP_REMOVE, pool_value());
    send_word(OP_DUMP, $urandom);
    pause_for_drain();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int  rand_start;
    bit  filled;
    bit  quiet_next;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_PUSH_FRONT;
    req_if.value     <= '0;
    rst_ni           <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The empty list first: a dump gives one empty word and
    // a removal reports not found.
    send_word(OP_DUMP, 32'h1234_5678);
    send_word(OP_REMOVE, 32'h0000_0000);
    // Build [0, max, min, -1, max] using both ends.
    send_word(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(OP_PUSH_BACK, 32'h8000_0000);
    send_word(OP_PUSH_FRONT, 32'h0000_0000);
    send_word(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_word(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(OP_DUMP, 32'hFFFF_FFFF);
    // Duplicate value: only the first match from the front goes.
    send_word(OP_REMOVE, 32'h7FFF_FFFF);
    send_word(OP_REMOVE, 32'h0000_0000);   // head
    send_word(OP_REMOVE, 32'hFFFF_FFFF);   // middle
    send_word(OP_REMOVE, 32'h7FFF_FFFF);   // tail
    send_word(OP_REMOVE, 32'h5555_AAAA);   // no match, list unchanged
    send_word(OP_DUMP, 32'h0000_0000);
    send_word(OP_REMOVE, 32'h8000_0000);   // last entry, list empty again
    send_word(OP_DUMP, 32'h0000_0000);
    // Freed slots are reused from the lowest one up.
    send_word(OP_PUSH_BACK, 32'hAAAA_5555);
    send_word(OP_PUSH_FRONT, 32'h5555_AAAA);
    send_word(OP_PUSH_BACK, 32'h0000_0001);
    send_word(OP_DUMP, 32'hAAAA_5555);
    pause_for_drain();

    // Random part: mixed episodes around one fill-to-capacity episode. The
    // first mixed episode after the fill runs with no idling at all.
    rand_start = items_sent;
    filled     = 1'b0;
    quiet_next = 1'b0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if (!filled && items_sent - rand_start >= 20) begin
        fill_episode();
        filled     = 1'b1;
        quiet_next = 1'b1;
      end else begin
        mixed_episode(20, quiet_next);
        quiet_next = 1'b0;
      end
    end

    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
